### sv/mqbf_pkg.sv
// Shared types and constants for the multi-queue byte FIFO.
// Operation, status and fill-mark codes, per-queue control entry, result record.
// No dependencies; the queue table, the top level and the testbench import this package.
package mqbf_pkg;

    localparam int NUM_QUEUES_DEF     = 8;
    localparam int MAX_QUEUE_SIZE_DEF = 256;
    localparam int STORE_DEPTH_DEF    = 1024;

    // Queue ids are 3 bits wide, so at most eight slots can ever be reached
    localparam int ID_SLOTS = 8;

    localparam int OP_W     = 3;
    localparam int QID_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int QSIZE_W  = 9;
    localparam int BASE_W   = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 3'd0,
        OP_GET    = 3'd1,
        OP_CREATE = 3'd2,
        OP_DELETE = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_SIZE  = 3'd3,
        ST_NO_SLOT   = 3'd4,
        ST_NOT_ALLOC = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MARK_NORMAL = 2'd0,
        MARK_FULL   = 2'd1,
        MARK_EMPTY  = 2'd2
    } mark_t;

    typedef struct packed {
        logic [INDEX_W-1:0] wr_idx;
        logic [INDEX_W-1:0] rd_idx;
        logic [INDEX_W-1:0] mask;
        mark_t              mark;
        logic [COUNT_W-1:0] count;
        logic [BASE_W-1:0]  base;
        logic               in_use;
    } qent_t;

    typedef struct packed {
        status_t            status;
        logic               get_ok;
        logic [QID_W-1:0]   created_id;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
    } op_result_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

### sv/mqbf_ram.sv
// Generic single-port RAM with registered read data.
// Parameters set word width and depth; no package dependency.
// Holds the shared byte store of the multi-queue byte FIFO.
module mqbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/mqbf_qtable.sv
// Queue control table: per-slot indices, masks, marks and counts, plus the
// single-pass operation decode that updates one entry and drives the store port.
// Depends on mqbf_pkg.
module mqbf_qtable
    import mqbf_pkg::*;
#(
    parameter int NUM_QUEUES     = NUM_QUEUES_DEF,
    parameter int MAX_QUEUE_SIZE = MAX_QUEUE_SIZE_DEF,
    parameter int STORE_DEPTH    = STORE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [OP_W-1:0]                operation,
    input  logic [QID_W-1:0]               queue_id,
    input  logic [QSIZE_W-1:0]             queue_size,
    input  logic [BASE_W-1:0]              buffer_base,
    output mem_ctl_t                       mem_ctl,
    output logic [$clog2(STORE_DEPTH)-1:0] mem_addr,
    output op_result_t                     result
);

    localparam int SLOTS  = (NUM_QUEUES < ID_SLOTS) ? NUM_QUEUES : ID_SLOTS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int SUM_W  = BASE_W + 1;

    qent_t              table_reg [SLOTS];
    qent_t              cur;
    qent_t              ent_next;
    logic               ent_we;
    logic [SLOT_W-1:0]  ent_slot;
    logic               q_in_range;
    logic [SLOT_W-1:0]  qi;
    logic               q_valid;
    logic               free_found;
    logic [SLOT_W-1:0]  free_slot;
    logic               size_bad;
    logic [INDEX_W-1:0] idx_sel;
    logic [INDEX_W-1:0] step_idx;
    logic [SUM_W-1:0]   addr_sum;
    logic [31:0]        addr_wrap;

    function automatic logic [COUNT_W-1:0] free_of(logic [COUNT_W-1:0] used,
                                                   logic [INDEX_W-1:0] mask);
        logic [COUNT_W-1:0] size;
        size = {1'b0, mask} + COUNT_W'(1);
        return (used <= size) ? (size - used) : '0;
    endfunction

    assign q_in_range = ({1'b0, queue_id} < 4'(SLOTS));
    assign qi         = q_in_range ? queue_id[SLOT_W-1:0] : '0;
    assign cur        = table_reg[qi];
    assign q_valid    = q_in_range && cur.in_use;

    assign size_bad = (queue_size == '0)
                   || (queue_size > QSIZE_W'(MAX_QUEUE_SIZE))
                   || ((queue_size & (queue_size - QSIZE_W'(1))) != '0);

    // Lowest free slot for create
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!table_reg[s].in_use && !free_found)
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    // Decode one operation; at most one table entry and one store byte change
    always_comb
    begin
        ent_we   = 1'b0;
        ent_slot = qi;
        ent_next = cur;
        mem_ctl  = '0;
        idx_sel  = cur.wr_idx;
        step_idx = '0;
        result   = '0;
        result.status = ST_OK;

        unique case (op_t'(operation))
            OP_PUT:
            begin
                if (!q_valid)
                begin
                    result.status = ST_NOT_ALLOC;
                end
                else
                begin
                    if (cur.mark != MARK_FULL)
                    begin
                        step_idx       = (cur.wr_idx + INDEX_W'(1)) & cur.mask;
                        idx_sel        = cur.wr_idx;
                        mem_ctl.we     = 1'b1;
                        ent_we         = 1'b1;
                        ent_next.count = cur.count + COUNT_W'(1);
                        if (cur.mark == MARK_EMPTY)
                        begin
                            ent_next.mark = MARK_NORMAL;
                        end
                        if (step_idx == cur.rd_idx)
                        begin
                            ent_next.mark = MARK_FULL;
                        end
                        ent_next.wr_idx = step_idx;
                    end
                    else
                    begin
                        result.status = ST_FULL;
                    end
                    result.used_count = ent_next.count;
                    result.free_count = free_of(ent_next.count, ent_next.mask);
                end
            end
            OP_GET:
            begin
                if (!q_valid)
                begin
                    result.status = ST_NOT_ALLOC;
                end
                else
                begin
                    if (cur.mark != MARK_EMPTY)
                    begin
                        step_idx       = (cur.rd_idx + INDEX_W'(1)) & cur.mask;
                        idx_sel        = cur.rd_idx;
                        mem_ctl.re     = 1'b1;
                        result.get_ok  = 1'b1;
                        ent_we         = 1'b1;
                        ent_next.count = cur.count - COUNT_W'(1);
                        if (cur.mark == MARK_FULL)
                        begin
                            ent_next.mark = MARK_NORMAL;
                        end
                        if (step_idx == cur.wr_idx)
                        begin
                            ent_next.mark = MARK_EMPTY;
                        end
                        ent_next.rd_idx = step_idx;
                    end
                    else
                    begin
                        result.status = ST_EMPTY;
                    end
                    result.used_count = ent_next.count;
                    result.free_count = free_of(ent_next.count, ent_next.mask);
                end
            end
            OP_CREATE:
            begin
                if (size_bad)
                begin
                    result.status = ST_BAD_SIZE;
                end
                else if (!free_found)
                begin
                    result.status = ST_NO_SLOT;
                end
                else
                begin
                    ent_we            = 1'b1;
                    ent_slot          = free_slot;
                    ent_next          = '0;
                    ent_next.mask     = INDEX_W'(queue_size - QSIZE_W'(1));
                    ent_next.mark     = MARK_EMPTY;
                    ent_next.base     = buffer_base;
                    ent_next.in_use   = 1'b1;
                    result.created_id = QID_W'(free_slot);
                    result.used_count = '0;
                    result.free_count = free_of('0, ent_next.mask);
                end
            end
            OP_DELETE:
            begin
                if (q_in_range)
                begin
                    ent_we        = 1'b1;
                    ent_next      = '0;
                    ent_next.mark = MARK_NORMAL;
                end
            end
            OP_QUERY:
            begin
                if (!q_valid)
                begin
                    result.status = ST_NOT_ALLOC;
                end
                else
                begin
                    result.used_count = cur.count;
                    result.free_count = free_of(cur.count, cur.mask);
                end
            end
            default:
            begin
                result.status = ST_OK;
            end
        endcase
    end

    // Store address: base plus index, folded into the store depth.
    // The sum stays below five times the smallest depth.
    assign addr_sum = {1'b0, cur.base} + SUM_W'(idx_sel);

    always_comb
    begin
        addr_wrap = 32'(addr_sum);
        for (int k = 1; k <= 4; k++)
        begin
            if (32'(addr_sum) >= 32'(k * STORE_DEPTH))
            begin
                addr_wrap = 32'(addr_sum) - 32'(k * STORE_DEPTH);
            end
        end
    end

    assign mem_addr = addr_wrap[ADDR_W-1:0];

    // An all-zero entry is a free slot with a normal mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                table_reg[s] <= '0;
            end
        end
        else if (fire && ent_we)
        begin
            table_reg[ent_slot] <= ent_next;
        end
    end

endmodule

### sv/multi_queue_byte_fifo.sv
// Multi-queue byte FIFO: up to eight byte queues sharing one byte store.
// An accepted transaction is registered in the result stage, then in the output register.
// Throughput: one operation per cycle unless the output stalls, set by the single store port
// and the one control-table write that each operation needs.
// Reset (rst_n low, asynchronous): all slots free and cleared, pipeline empty;
// store contents stay undefined until written.
module multi_queue_byte_fifo
    import mqbf_pkg::*;
#(
    parameter int NUM_QUEUES     = NUM_QUEUES_DEF,
    parameter int MAX_QUEUE_SIZE = MAX_QUEUE_SIZE_DEF,
    parameter int STORE_DEPTH    = STORE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // queue_id[2:0], data_byte[10:3], queue_size[19:11], buffer_base[29:20], zero[31:30]
    input  logic [31:0] s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], data_out[10:3], created_id[13:11], used_count[22:14], free_count[31:23]
    output logic [31:0] m_axis_tdata
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // Unpacked request fields
    logic [QID_W-1:0]   queue_id;
    logic [BYTE_W-1:0]  data_byte;
    logic [QSIZE_W-1:0] queue_size;
    logic [BASE_W-1:0]  buffer_base;

    logic               fire;
    mem_ctl_t           mem_ctl;
    logic [ADDR_W-1:0]  mem_addr;
    logic [BYTE_W-1:0]  mem_rdata;
    op_result_t         qt_result;

    // Result stage: control outcome of the last operation, store read in flight
    logic               res_valid_reg;
    logic               res_valid_next;
    op_result_t         res_reg;
    logic               res_advance;

    // Output register: the finished transaction waiting for the consumer
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        out_data_reg;
    logic [BYTE_W-1:0]  data_out;

    assign queue_id    = s_axis_tdata[2:0];
    assign data_byte   = s_axis_tdata[10:3];
    assign queue_size  = s_axis_tdata[19:11];
    assign buffer_base = s_axis_tdata[29:20];

    // Advance the result stage whenever the output register is free or draining;
    // accept a new transaction whenever the result stage will be free.
    assign res_advance   = res_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !res_valid_reg || res_advance;
    assign fire          = s_axis_tvalid && s_axis_tready;

    mqbf_qtable #(
        .NUM_QUEUES     (NUM_QUEUES),
        .MAX_QUEUE_SIZE (MAX_QUEUE_SIZE),
        .STORE_DEPTH    (STORE_DEPTH)
    ) u_qtable (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .operation   (s_axis_tuser),
        .queue_id    (queue_id),
        .queue_size  (queue_size),
        .buffer_base (buffer_base),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .result      (qt_result)
    );

    // Shared byte store; read data stays put until the next get, which cannot
    // be accepted before the pending result has moved on.
    mqbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (fire && mem_ctl.we),
        .re    (fire && mem_ctl.re),
        .addr  (mem_addr),
        .wdata (data_byte),
        .rdata (mem_rdata)
    );

    assign res_valid_next = fire || (res_valid_reg && !res_advance);
    assign out_valid_next = res_advance || (out_valid_reg && !m_axis_tready);

    // Drop the stale store word unless this transaction was a successful get
    assign data_out = res_reg.get_ok ? mem_rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= qt_result;
        end
        if (res_advance)
        begin
            out_data_reg <= {res_reg.free_count, res_reg.used_count, res_reg.created_id,
                             data_out, res_reg.status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Input backpressure only when both the result stage and the output are full
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (res_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while a pipeline stage was free");

    a_fire_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("accepted transaction did not reach the result stage");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        res_advance |=> out_valid_reg)
        else $error("advanced result did not reach the output register");

    a_get_reads_store: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && qt_result.get_ok) |-> (mem_ctl.re && !mem_ctl.we))
        else $error("successful get without a store read");

endmodule

### bench/multi_queue_byte_fifo_tb.sv
// Self-checking testbench for multi_queue_byte_fifo: directed rows, then random queue traffic.
// Expected results come from a behavioral model of the queue table and byte store kept here.
// Depends on mqbf_pkg and the multi_queue_byte_fifo RTL.
module multi_queue_byte_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mqbf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PCT      = 20;
    localparam int RANDOM_ITEMS  = 930;
    localparam int HOLD_AT       = 150;      // random item at which the output side stalls
    localparam int HOLD_CYCLES   = 300;
    localparam int PAUSE_AT      = 400;      // random item before which the input side drains
    localparam int QUIET_FROM    = 600;      // stretch with no idling on either side
    localparam int QUIET_TO      = 780;
    localparam int BIAS_SPAN     = 120;      // items per fill / drain phase
    localparam int END_CYCLES    = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    // Operation codes the block ignores
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

    // Laid out so that a cast from m_axis_tdata lands each field in place (status lowest)
    typedef struct packed {
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] used_count;
        logic [QID_W-1:0]   created_id;
        logic [BYTE_W-1:0]  data_out;
        status_t            status;
    } fifo_result_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [QID_W-1:0]   qid;
        logic [BYTE_W-1:0]  data;
        logic [QSIZE_W-1:0] qsize;
        logic [BASE_W-1:0]  qbase;
        bit                 pinned;     // expected result typed into the row
        fifo_result_t       want;
    } op_row_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata   = '0;   // queue_id, data_byte, queue_size, buffer_base, zero
    logic [2:0]  s_axis_tuser   = '0;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [31:0] m_axis_tdata;          // status, data_out, created_id, used_count, free_count

    // Behavioral copy of the queue table and the shared byte store
    logic [INDEX_W-1:0] q_wr    [NUM_QUEUES_DEF];
    logic [INDEX_W-1:0] q_rd    [NUM_QUEUES_DEF];
    logic [INDEX_W-1:0] q_mask  [NUM_QUEUES_DEF];
    mark_t              q_mark  [NUM_QUEUES_DEF];
    logic [COUNT_W-1:0] q_count [NUM_QUEUES_DEF];
    logic [BASE_W-1:0]  q_base  [NUM_QUEUES_DEF];
    bit                 q_live  [NUM_QUEUES_DEF];
    logic [BYTE_W-1:0]  byte_image [STORE_DEPTH_DEF];

    fifo_result_t expected_results [$];
    op_row_t      directed_ops [$];
    int           fail_count  = 0;
    bit           tx_idle_on  = 1'b1;
    bit           rx_idle_on  = 1'b1;
    bit           hold_output = 1'b0;

    multi_queue_byte_fifo DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    function automatic void clear_slot(int q);
        q_wr[q]    = '0;
        q_rd[q]    = '0;
        q_mask[q]  = '0;
        q_mark[q]  = MARK_NORMAL;
        q_count[q] = '0;
        q_base[q]  = '0;
        q_live[q]  = 1'b0;
    endfunction

    // Fill in used and free bytes of a slot; free never goes below zero
    function automatic fifo_result_t with_counts(fifo_result_t r, int q);
        logic [COUNT_W-1:0] cap;
        cap = COUNT_W'(q_mask[q]) + 1'b1;
        r.used_count = q_count[q];
        r.free_count = (q_count[q] <= cap) ? cap - q_count[q] : '0;
        return r;
    endfunction

    // Apply one operation to the queue table and return the result it produces
    function automatic fifo_result_t predict_op(op_row_t t);
        fifo_result_t       r;
        logic [INDEX_W-1:0] nxt;
        logic [BASE_W-1:0]  addr;
        int                 slot;
        r = '0;
        case (t.op)
            OP_PUT:
            begin
                if (!q_live[t.qid])
                    r.status = ST_NOT_ALLOC;
                else
                begin
                    if (q_mark[t.qid] != MARK_FULL)
                    begin
                        nxt  = (q_wr[t.qid] + 1'b1) & q_mask[t.qid];
                        // store depth is 2**BASE_W, so the sum wraps by truncation
                        addr = q_base[t.qid] + BASE_W'(q_wr[t.qid]);
                        byte_image[addr] = t.data;
                        q_count[t.qid]   = q_count[t.qid] + 1'b1;
                        if (q_mark[t.qid] == MARK_EMPTY)
                            q_mark[t.qid] = MARK_NORMAL;
                        if (nxt == q_rd[t.qid])
                            q_mark[t.qid] = MARK_FULL;
                        q_wr[t.qid] = nxt;
                    end
                    else
                        r.status = ST_FULL;
                    r = with_counts(r, t.qid);
                end
            end
            OP_GET:
            begin
                if (!q_live[t.qid])
                    r.status = ST_NOT_ALLOC;
                else
                begin
                    if (q_mark[t.qid] != MARK_EMPTY)
                    begin
                        nxt  = (q_rd[t.qid] + 1'b1) & q_mask[t.qid];
                        addr = q_base[t.qid] + BASE_W'(q_rd[t.qid]);
                        r.data_out     = byte_image[addr];
                        q_count[t.qid] = q_count[t.qid] - 1'b1;
                        if (q_mark[t.qid] == MARK_FULL)
                            q_mark[t.qid] = MARK_NORMAL;
                        if (nxt == q_wr[t.qid])
                            q_mark[t.qid] = MARK_EMPTY;
                        q_rd[t.qid] = nxt;
                    end
                    else
                        r.status = ST_EMPTY;
                    r = with_counts(r, t.qid);
                end
            end
            OP_CREATE:
            begin
                if (t.qsize == '0 || t.qsize > MAX_QUEUE_SIZE_DEF ||
                    (t.qsize & (t.qsize - 1'b1)) != '0)
                    r.status = ST_BAD_SIZE;
                else
                begin
                    // lowest free slot wins
                    slot = -1;
                    for (int s = NUM_QUEUES_DEF - 1; s >= 0; s--)
                        if (!q_live[s])
                            slot = s;
                    if (slot < 0)
                        r.status = ST_NO_SLOT;
                    else
                    begin
                        q_wr[slot]    = '0;
                        q_rd[slot]    = '0;
                        q_mask[slot]  = INDEX_W'(t.qsize - 1'b1);
                        q_mark[slot]  = MARK_EMPTY;
                        q_count[slot] = '0;
                        q_base[slot]  = t.qbase;
                        q_live[slot]  = 1'b1;
                        r.created_id  = QID_W'(slot);
                        r = with_counts(r, slot);
                    end
                end
            end
            OP_DELETE:
                clear_slot(t.qid);
            OP_QUERY:
            begin
                if (!q_live[t.qid])
                    r.status = ST_NOT_ALLOC;
                else
                    r = with_counts(r, t.qid);
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic fifo_result_t res(status_t st, logic [BYTE_W-1:0] dout,
                                         logic [QID_W-1:0] id, logic [COUNT_W-1:0] used,
                                         logic [COUNT_W-1:0] free_bytes);
        fifo_result_t r;
        r.status     = st;
        r.data_out   = dout;
        r.created_id = id;
        r.used_count = used;
        r.free_count = free_bytes;
        return r;
    endfunction

    function automatic op_row_t row(logic [OP_W-1:0] op, logic [QID_W-1:0] qid,
                                    logic [BYTE_W-1:0] data, logic [QSIZE_W-1:0] qsize,
                                    logic [BASE_W-1:0] qbase, bit pinned, fifo_result_t want);
        op_row_t t;
        t.op     = op;
        t.qid    = qid;
        t.data   = data;
        t.qsize  = qsize;
        t.qbase  = qbase;
        t.pinned = pinned;
        t.want   = want;
        return t;
    endfunction

    // Mostly address a live slot; now and then any slot so unallocated access shows up
    function automatic logic [QID_W-1:0] pick_live_slot();
        logic [QID_W-1:0] live [$];
        for (int s = 0; s < NUM_QUEUES_DEF; s++)
            if (q_live[s])
                live.push_back(QID_W'(s));
        if (live.size() == 0 || $urandom_range(0, 9) == 0)
            return QID_W'($urandom_range(0, NUM_QUEUES_DEF - 1));
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic void log_failure(string what, fifo_result_t want, fifo_result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: exp st=%0d d=%h id=%0d u=%0d f=%0d / got st=%0d d=%h id=%0d u=%0d f=%0d",
                     $time, what, want.status, want.data_out, want.created_id,
                     want.used_count, want.free_count, got.status, got.data_out,
                     got.created_id, got.used_count, got.free_count);
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic send_op(input op_row_t t);
        fifo_result_t predicted;
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.op;
        s_axis_tdata  <= {2'b00, t.qbase, t.qsize, t.data, t.qid};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predicted = predict_op(t);
        expected_results.push_back(t.pinned ? t.want : predicted);
    endtask

    // Output side: random back-pressure, plus one long stall requested by the stimulus
    initial
    begin : result_drain
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else
                m_axis_tready <= !rx_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare every accepted result with the oldest outstanding expectation
    always @(posedge clk)
    begin : result_check
        fifo_result_t got;
        fifo_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = fifo_result_t'(m_axis_tdata);
            if (expected_results.size() == 0)
                log_failure("unexpected result", '0, got);
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.data_out !== want.data_out ||
                    got.created_id !== want.created_id ||
                    got.used_count !== want.used_count ||
                    got.free_count !== want.free_count)
                    log_failure("mismatch", want, got);
            end
        end
    end

    initial
    begin : stimulus
        op_row_t t;
        int      n;
        int      ops_counted;
        int      roll;
        int      guard;
        bit      fill_phase;

        for (int q = 0; q < NUM_QUEUES_DEF; q++)
            clear_slot(q);

        // Directed rows: pinned results are the ones obvious from the spec
        // every slot is free after reset
        directed_ops.push_back(row(OP_QUERY, 3'd0, 8'h00, 9'd0, 10'd0, 1'b1,
                                   res(ST_NOT_ALLOC, 8'h00, 3'd0, 9'd0, 9'd0)));
        directed_ops.push_back(row(OP_PUT, 3'd7, 8'hFF, 9'd0, 10'd0, 1'b1,
                                   res(ST_NOT_ALLOC, 8'h00, 3'd0, 9'd0, 9'd0)));
        // zero, all-ones and non-power-of-two sizes are rejected
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd0, 10'd0, 1'b1,
                                   res(ST_BAD_SIZE, 8'h00, 3'd0, 9'd0, 9'd0)));
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd511, 10'd0, 1'b1,
                                   res(ST_BAD_SIZE, 8'h00, 3'd0, 9'd0, 9'd0)));
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd3, 10'd0, 1'b1,
                                   res(ST_BAD_SIZE, 8'h00, 3'd0, 9'd0, 9'd0)));
        // one-byte queue at the top of the store: empty, full and back
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd1, 10'd1023, 1'b1,
                                   res(ST_OK, 8'h00, 3'd0, 9'd0, 9'd1)));
        directed_ops.push_back(row(OP_GET, 3'd0, 8'h00, 9'd0, 10'd0, 1'b1,
                                   res(ST_EMPTY, 8'h00, 3'd0, 9'd0, 9'd1)));
        directed_ops.push_back(row(OP_PUT, 3'd0, 8'hFF, 9'd0, 10'd0, 1'b1,
                                   res(ST_OK, 8'h00, 3'd0, 9'd1, 9'd0)));
        directed_ops.push_back(row(OP_PUT, 3'd0, 8'h00, 9'd0, 10'd0, 1'b1,
                                   res(ST_FULL, 8'h00, 3'd0, 9'd1, 9'd0)));
        directed_ops.push_back(row(OP_GET, 3'd0, 8'h00, 9'd0, 10'd0, 1'b1,
                                   res(ST_OK, 8'hFF, 3'd0, 9'd0, 9'd1)));
        // largest queue, placed so its span wraps past the end of the store
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd256, 10'd1000, 1'b1,
                                   res(ST_OK, 8'h00, 3'd1, 9'd0, 9'd256)));
        directed_ops.push_back(row(OP_PUT, 3'd1, 8'h00, 9'd0, 10'd0, 1'b0, '0));
        directed_ops.push_back(row(OP_PUT, 3'd1, 8'hA5, 9'd0, 10'd0, 1'b0, '0));
        directed_ops.push_back(row(OP_QUERY, 3'd1, 8'h00, 9'd0, 10'd0, 1'b0, '0));
        directed_ops.push_back(row(OP_GET, 3'd1, 8'h00, 9'd0, 10'd0, 1'b0, '0));
        // fill the remaining slots
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd2, 10'd0, 1'b0, '0));
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd128, 10'd256, 1'b0, '0));
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd64, 10'd512, 1'b0, '0));
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd4, 10'd1020, 1'b0, '0));
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd8, 10'd700, 1'b0, '0));
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd16, 10'd800, 1'b0, '0));
        // table full
        directed_ops.push_back(row(OP_CREATE, 3'd0, 8'h00, 9'd32, 10'd0, 1'b1,
                                   res(ST_NO_SLOT, 8'h00, 3'd0, 9'd0, 9'd0)));
        directed_ops.push_back(row(OP_DELETE, 3'd3, 8'h00, 9'd0, 10'd0, 1'b1,
                                   res(ST_OK, 8'h00, 3'd0, 9'd0, 9'd0)));
        // unknown operations answer with all zeros
        directed_ops.push_back(row(OP_RESERVED_LO, 3'd5, 8'h5A, 9'd8, 10'd0, 1'b1,
                                   res(ST_OK, 8'h00, 3'd0, 9'd0, 9'd0)));
        directed_ops.push_back(row(OP_RESERVED_HI, 3'd7, 8'hFF, 9'd511, 10'd1023, 1'b1,
                                   res(ST_OK, 8'h00, 3'd0, 9'd0, 9'd0)));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
            send_op(directed_ops[i]);

        // Random traffic: alternate fill-heavy and drain-heavy phases so queues
        // hit both full and empty; sprinkle creates, deletes, bad sizes and junk ops
        ops_counted = 0;
        for (n = 0; ops_counted < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_AT)
                hold_output = 1'b1;     // keep offering while the output side stalls
            if (n == PAUSE_AT)
            begin
                // drain every outstanding result before going on
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            tx_idle_on = !(n >= QUIET_FROM && n < QUIET_TO);
            rx_idle_on = tx_idle_on;

            fill_phase = ((n / BIAS_SPAN) % 2) == 0;
            roll       = $urandom_range(0, 99);
            t          = row(OP_QUERY, pick_live_slot(), 8'($urandom_range(0, 255)),
                             9'($urandom_range(0, 511)), 10'($urandom_range(0, 1023)),
                             1'b0, '0);
            if (roll < (fill_phase ? 50 : 20))
                t.op = OP_PUT;
            else if (roll < 72)
                t.op = OP_GET;
            else if (roll < 80)
                t.op = OP_QUERY;
            else if (roll < 88)
            begin
                // legal size, mostly small, now and then up to the maximum
                t.op    = OP_CREATE;
                t.qsize = 9'd1 << (($urandom_range(0, 7) == 0) ? $urandom_range(0, 8)
                                                                : $urandom_range(0, 4));
            end
            else if (roll < 93)
                t.op = OP_DELETE;
            else if (roll < 97)
                t.op = OP_CREATE;       // raw size, mostly illegal
            else
                t.op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));

            send_op(t);
            if (t.op < OP_RESERVED_LO)
                ops_counted++;
        end
        s_axis_tvalid <= 1'b0;

        // Wait out the remaining results, bounded
        guard = 0;
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (END_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            $display("%0d expected results never arrived", expected_results.size());
        if (fail_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
